// ===== rtl/spd_pkg.sv =====
// Shared types and constants for the sensor packet deframer.
// No dependencies; imported by the core, the top level and the checker.
package spd_pkg;

    localparam int unsigned CNT_W         = 3;
    localparam int unsigned IR_OUT_FIELDS = 6;

    localparam logic [7:0] HDR_GYRO   = 8'h47;  // 'G'
    localparam logic [7:0] HDR_IR     = 8'h49;  // 'I'
    localparam logic [7:0] HDR_REFLEX = 8'h52;  // 'R'

    typedef enum logic [1:0] {
        KIND_IDLE   = 2'd0,
        KIND_GYRO   = 2'd1,
        KIND_IR     = 2'd2,
        KIND_REFLEX = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_GYRO   = 2'd1,
        EV_IR     = 2'd2,
        EV_REFLEX = 2'd3
    } event_t;

    typedef struct packed {
        event_t                                event_res;
        logic                                  send_reflex_request;
        logic signed [15:0]                    gyro_rate;
        logic [15:0]                           reflex_left;
        logic [15:0]                           reflex_right;
        logic [IR_OUT_FIELDS-1:0][7:0]         ir;
    } spd_result_t;

endpackage

// ===== rtl/sensor_packet_deframer.sv =====
// Top level of the sensor packet deframer: stream handshake, input and result registers.
// Depends on spd_pkg and spd_core.
//
//  channel | dir | payload                                                  | accept
//  s_*     | in  | tdata[7:0] rx_byte                                       | s_tvalid & s_tready
//  m_*     | out | tdata gyro/reflex/ir bytes, tuser event and request flag | m_tvalid & m_tready
//
// One item per clock sustained while the m side is not stalled; an accepted item is loaded
// into the input register on accept, then into the result register on the next advance.
// rst_n clears the parser to idle, the core value registers to zero and both valid flags.
// A stalled m side holds the result; the input register still takes one more item,
// and s_tready drops only when both registers are full and m_tready is low.
module sensor_packet_deframer
    import spd_pkg::*;
#(
    parameter int unsigned IR_BYTES = 6
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // gyro_rate, reflex_left, reflex_right, ir_0 .. ir_5
    output logic [2:0]  m_tuser    // [1:0] event_res, [2] send_reflex_request
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg;
    spd_result_t out_reg;
    spd_result_t result;
    logic        advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    spd_core #(
        .IR_BYTES (IR_BYTES)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .rx_byte (in_byte_reg),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_byte_reg <= s_tdata;
        if (advance)
            out_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = {out_reg.send_reflex_request, out_reg.event_res};
    assign m_tdata  = {out_reg.ir[5], out_reg.ir[4], out_reg.ir[3],
                       out_reg.ir[2], out_reg.ir[1], out_reg.ir[0],
                       out_reg.reflex_right, out_reg.reflex_left,
                       out_reg.gyro_rate};

endmodule

// ===== rtl/spd_core.sv =====
// Packet parser state and register file of the sensor packet deframer.
// Depends on spd_pkg; the top level feeds it one byte per advance.
module spd_core
    import spd_pkg::*;
#(
    parameter int unsigned IR_BYTES = 6
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  logic [7:0]  rx_byte,
    output spd_result_t result
);

    localparam logic [CNT_W:0] IR_COUNT = (CNT_W+1)'(IR_BYTES);

    kind_t                      kind_reg, kind_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [7:0]                 hold_reg, hold_next;
    logic [15:0]                gyro_reg, gyro_next;
    logic [15:0]                left_reg, left_next;
    logic [15:0]                right_reg, right_next;
    logic [IR_BYTES-1:0][7:0]   ir_reg, ir_next;
    event_t                     ev;
    logic                       req;
    logic [15:0]                gyro_word;

    assign gyro_word = {hold_reg, rx_byte};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg  <= KIND_IDLE;
            count_reg <= '0;
            hold_reg  <= '0;
            gyro_reg  <= '0;
            left_reg  <= '0;
            right_reg <= '0;
            ir_reg    <= '0;
        end
        else if (advance)
        begin
            kind_reg  <= kind_next;
            count_reg <= count_next;
            hold_reg  <= hold_next;
            gyro_reg  <= gyro_next;
            left_reg  <= left_next;
            right_reg <= right_next;
            ir_reg    <= ir_next;
        end
    end

    always_comb
    begin
        kind_next  = kind_reg;
        count_next = count_reg;
        hold_next  = hold_reg;
        gyro_next  = gyro_reg;
        left_next  = left_reg;
        right_next = right_reg;
        ir_next    = ir_reg;
        ev         = EV_NONE;
        req        = 1'b0;

        unique case (kind_reg)
            KIND_GYRO:
            begin
                if (count_reg == '0)
                begin
                    hold_next  = rx_byte;
                    count_next = CNT_W'(1);
                end
                else
                begin
                    // a zero rate is reserved, report it as one
                    gyro_next  = (gyro_word == 16'd0) ? 16'd1 : gyro_word;
                    kind_next  = KIND_IDLE;
                    count_next = '0;
                    ev         = EV_GYRO;
                end
            end
            KIND_IR:
            begin
                for (int unsigned k = 0; k < IR_BYTES; k++)
                begin
                    if (count_reg == CNT_W'(k))
                        ir_next[k] = rx_byte;
                end
                if ({1'b0, count_reg} + (CNT_W+1)'(1) >= IR_COUNT)
                begin
                    kind_next  = KIND_IDLE;
                    count_next = '0;
                    ev         = EV_IR;
                    req        = 1'b1;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            KIND_REFLEX:
            begin
                unique case (count_reg[1:0])
                    2'd0:    left_next  = {8'd0, rx_byte};
                    2'd1:    left_next  = {left_reg[7:0], rx_byte};
                    2'd2:    right_next = {8'd0, rx_byte};
                    default:
                    begin
                        right_next = {right_reg[7:0], rx_byte};
                        ev         = EV_REFLEX;
                    end
                endcase
                if (ev == EV_REFLEX)
                begin
                    kind_next  = KIND_IDLE;
                    count_next = '0;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            default:
            begin
                hold_next  = '0;
                count_next = '0;
                priority if (rx_byte == HDR_GYRO)
                    kind_next = KIND_GYRO;
                else if (rx_byte == HDR_IR)
                    kind_next = KIND_IR;
                else if (rx_byte == HDR_REFLEX)
                    kind_next = KIND_REFLEX;
                else
                    kind_next = KIND_IDLE;
            end
        endcase
    end

    assign result.event_res           = ev;
    assign result.send_reflex_request = req;
    assign result.gyro_rate           = gyro_next;
    assign result.reflex_left         = left_next;
    assign result.reflex_right        = right_next;

    // slots past the configured IR length read as zero
    for (genvar g = 0; g < IR_OUT_FIELDS; g++)
    begin : g_ir_out
        if (g < IR_BYTES)
        begin : g_used
            assign result.ir[g] = ir_next[g];
        end
        else
        begin : g_unused
            assign result.ir[g] = 8'd0;
        end
    end

endmodule

// ===== rtl/spd_checker.sv =====
// Port-level checks for the sensor packet deframer, bound to its top level.
// Depends on spd_pkg and sensor_packet_deframer.
module spd_checker
    import spd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata,
    input logic [2:0]  m_tuser
);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // the reflex query goes out exactly with an IR completion
    a_req: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser[2] == (m_tuser[1:0] == EV_IR)))
        else $error("reflex request does not match IR event");

    // a finished gyro packet never reports zero
    a_gyro_nz: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1:0] == EV_GYRO |-> m_tdata[15:0] != 16'd0)
        else $error("gyro event with zero rate");

    // once the gyro rate is nonzero it stays nonzero
    a_gyro_stay: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && $past(m_tvalid) && $past(m_tdata[15:0]) != 16'd0
            |-> m_tdata[15:0] != 16'd0)
        else $error("gyro rate fell back to zero");

endmodule

bind sensor_packet_deframer spd_checker u_spd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
